// ----- src/mcmp_pkg.sv -----
// ----------------------------------------------------------------------------
// mcmp_pkg
// shared constants for the multinomial coefficient block (modulus, barrett
// reduction constant, field widths)
// ----------------------------------------------------------------------------
package mcmp_pkg;

  localparam int FieldW = 12;
  localparam int CoefW  = 30;

  localparam logic [CoefW-1:0] Prime  = 30'd1000000007;
  // exponent for the fermat inverse
  localparam logic [CoefW-1:0] PowExp = 30'd1000000005;
  // floor(2^60 / prime)
  localparam logic [30:0]      BarrettMu = 31'd1152921496;

  localparam int TableDepthDef = 4096;

endpackage

// ----- src/mcmp_ram.sv -----
// ----------------------------------------------------------------------------
// mcmp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mcmp_ram #(
  parameter int Width = 30,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/mcmp_mulmod.sv -----
// ----------------------------------------------------------------------------
// mcmp_mulmod
// five stage modular multiplier, a * b mod prime, barrett reduction
// ----------------------------------------------------------------------------
module mcmp_mulmod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [mcmp_pkg::CoefW-1:0] a_i,
  input  logic [mcmp_pkg::CoefW-1:0] b_i,
  output logic                      valid_o,
  output logic [mcmp_pkg::CoefW-1:0] res_o
);
  import mcmp_pkg::*;

  logic [4:0]  v_q;
  logic [59:0] x_q;
  logic [30:0] q_q;
  logic [31:0] xlo2_q, xlo3_q;
  logic [31:0] qp_q;
  logic [31:0] r_q;
  logic [CoefW-1:0] res_q;

  logic [61:0] q_full;
  logic [61:0] qp_full;
  logic [31:0] p32, p2x32;
  logic [CoefW-1:0] res_d;

  assign q_full  = 62'(x_q[59:29]) * 62'(BarrettMu);
  assign qp_full = 62'(q_q) * 62'(Prime);
  assign p32     = 32'(Prime);
  assign p2x32   = 32'(Prime) << 1;

  // remainder estimate is below three times the modulus
  always_comb begin
    if (r_q >= p2x32) begin
      res_d = CoefW'(r_q - p2x32);
    end else if (r_q >= p32) begin
      res_d = CoefW'(r_q - p32);
    end else begin
      res_d = CoefW'(r_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= 60'(a_i) * 60'(b_i);
      q_q    <= q_full[61:31];
      xlo2_q <= x_q[31:0];
      qp_q   <= qp_full[31:0];
      xlo3_q <= xlo2_q;
      r_q    <= xlo3_q - qp_q;
      res_q  <= res_d;
    end
  end

  assign valid_o = v_q[4];
  assign res_o   = res_q;

endmodule

// ----- src/multinomial_coefficient_mod_prime.sv -----
// ----------------------------------------------------------------------------
// multinomial_coefficient_mod_prime
// n! / (c1! c2! c3!) modulo 1000000007 from factorial and inverse tables
// ----------------------------------------------------------------------------
// After reset the block fills its tables before it takes any query: a forward
// pass writes i! mod p for every entry (one modular multiply each on the shared
// multiplier), one fermat exponentiation inverts the last factorial (45
// multiplies), and a backward pass writes each inverse factorial as
// inv((i)!) = inv((i+1)!) * (i+1). During the build in_stall_o stays high. Once
// built the tables are read only and a query transaction can enter every cycle
// while the output is not stalled; its result passes through one ram read
// register, three five stage modular multipliers and one output register. A
// stalled output freezes the whole pipeline, so throughput is one transaction
// per cycle while the output side takes them. Any count not below the table
// depth gives a coefficient of zero. The counts are not checked to sum to n.
// ----------------------------------------------------------------------------
module multinomial_coefficient_mod_prime #(
  parameter int TableDepth = mcmp_pkg::TableDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mcmp_pkg::FieldW-1:0] total_count_i,
  input  logic [mcmp_pkg::FieldW-1:0] first_class_count_i,
  input  logic [mcmp_pkg::FieldW-1:0] second_class_count_i,
  input  logic [mcmp_pkg::FieldW-1:0] third_class_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mcmp_pkg::CoefW-1:0]  coefficient_o
);
  import mcmp_pkg::*;

  localparam int AW = $clog2(TableDepth);
  localparam logic [AW-1:0] LastIdx = AW'(TableDepth - 1);
  localparam int Lat = 5;

  // build sequencer codes
  localparam logic [1:0] StFwd = 2'd0;
  localparam logic [1:0] StPow = 2'd1;
  localparam logic [1:0] StBwd = 2'd2;
  localparam logic [1:0] StRun = 2'd3;

  logic [1:0]       st_q, st_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [CoefW-1:0] acc_q, acc_d;
  logic [CoefW-1:0] base_q, base_d;
  logic [4:0]       bit_q, bit_d;
  logic             sq_q, sq_d;
  logic             pend_q, pend_d;

  logic             issue;
  logic [CoefW-1:0] bld_b;
  logic             ready;
  logic             en;
  logic             accept;

  // ram side
  logic             fact_we, inv_we;
  logic [CoefW-1:0] fact_rd, inv1_rd, inv2_rd, inv3_rd;

  // query pipeline
  logic             rv_q;
  logic             oob0_q;
  logic             oob_in;
  logic [CoefW-1:0] d2_q [Lat];
  logic [CoefW-1:0] d3_q [2*Lat];
  logic             oob_q [3*Lat];
  logic             out_v_q;
  logic [CoefW-1:0] out_q;

  logic             m1_v_i, m1_v, m2_v, m3_v;
  logic [CoefW-1:0] m1_a, m1_b, m1_r, m2_r, m3_r;

  assign ready = (st_q == StRun);
  // the whole pipeline holds while a result waits on a stalled output
  assign en     = !out_v_q || !out_stall_i;
  assign in_stall_o = !ready || !en;
  assign accept = in_valid_i && ready && en;

  // ---------------------------------------------------------------- build
  assign issue = !ready && !pend_q &&
                 !((st_q == StFwd) && (idx_q == LastIdx)) &&
                 !((st_q == StBwd) && (idx_q == '0));

  always_comb begin
    case (st_q)
      StFwd:   bld_b = CoefW'(idx_q) + CoefW'(1);
      StPow:   bld_b = sq_q ? acc_q : base_q;
      StBwd:   bld_b = CoefW'(idx_q);
      default: bld_b = acc_q;
    endcase
  end

  assign fact_we = (st_q == StFwd) && !pend_q;
  assign inv_we  = (st_q == StBwd) && !pend_q;

  always_comb begin
    st_d   = st_q;
    idx_d  = idx_q;
    acc_d  = acc_q;
    base_d = base_q;
    bit_d  = bit_q;
    sq_d   = sq_q;
    pend_d = pend_q;
    case (st_q)
      StFwd: begin
        if (!pend_q) begin
          if (idx_q == LastIdx) begin
            // start the exponentiation of the last factorial
            st_d   = StPow;
            base_d = acc_q;
            acc_d  = CoefW'(1);
            bit_d  = 5'(CoefW - 1);
            sq_d   = 1'b1;
          end else begin
            pend_d = 1'b1;
            idx_d  = idx_q + AW'(1);
          end
        end else if (m1_v) begin
          acc_d  = m1_r;
          pend_d = 1'b0;
        end
      end
      StPow: begin
        if (!pend_q) begin
          pend_d = 1'b1;
        end else if (m1_v) begin
          acc_d  = m1_r;
          pend_d = 1'b0;
          if (sq_q && PowExp[bit_q]) begin
            sq_d = 1'b0;
          end else if (bit_q == '0) begin
            st_d = StBwd;
          end else begin
            bit_d = bit_q - 5'd1;
            sq_d  = 1'b1;
          end
        end
      end
      StBwd: begin
        if (!pend_q) begin
          if (idx_q == '0) begin
            st_d = StRun;
          end else begin
            pend_d = 1'b1;
          end
        end else if (m1_v) begin
          acc_d  = m1_r;
          pend_d = 1'b0;
          idx_d  = idx_q - AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StFwd;
      idx_q  <= '0;
      acc_q  <= CoefW'(1);
      base_q <= '0;
      bit_q  <= '0;
      sq_q   <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      acc_q  <= acc_d;
      base_q <= base_d;
      bit_q  <= bit_d;
      sq_q   <= sq_d;
      pend_q <= pend_d;
    end
  end

  // ---------------------------------------------------------------- tables
  mcmp_ram #(.Width(CoefW), .Depth(TableDepth)) u_fact_ram (
    .clk_i     (clk_i),
    .we_i      (fact_we),
    .wr_addr_i (idx_q),
    .wr_data_i (acc_q),
    .rd_en_i   (en),
    .rd_addr_i (AW'(total_count_i)),
    .rd_data_o (fact_rd)
  );

  // three copies of the inverse table, one per class count
  mcmp_ram #(.Width(CoefW), .Depth(TableDepth)) u_inv1_ram (
    .clk_i     (clk_i),
    .we_i      (inv_we),
    .wr_addr_i (idx_q),
    .wr_data_i (acc_q),
    .rd_en_i   (en),
    .rd_addr_i (AW'(first_class_count_i)),
    .rd_data_o (inv1_rd)
  );

  mcmp_ram #(.Width(CoefW), .Depth(TableDepth)) u_inv2_ram (
    .clk_i     (clk_i),
    .we_i      (inv_we),
    .wr_addr_i (idx_q),
    .wr_data_i (acc_q),
    .rd_en_i   (en),
    .rd_addr_i (AW'(second_class_count_i)),
    .rd_data_o (inv2_rd)
  );

  mcmp_ram #(.Width(CoefW), .Depth(TableDepth)) u_inv3_ram (
    .clk_i     (clk_i),
    .we_i      (inv_we),
    .wr_addr_i (idx_q),
    .wr_data_i (acc_q),
    .rd_en_i   (en),
    .rd_addr_i (AW'(third_class_count_i)),
    .rd_data_o (inv3_rd)
  );

  // ---------------------------------------------------------------- query
  assign oob_in = (int'(total_count_i) >= TableDepth) ||
                  (int'(first_class_count_i) >= TableDepth) ||
                  (int'(second_class_count_i) >= TableDepth) ||
                  (int'(third_class_count_i) >= TableDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      rv_q    <= accept;
      out_v_q <= m3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oob0_q <= oob_in;
      d2_q[0]  <= inv2_rd;
      d3_q[0]  <= inv3_rd;
      oob_q[0] <= oob0_q;
      for (int i = 1; i < Lat; i++) begin
        d2_q[i] <= d2_q[i-1];
      end
      for (int i = 1; i < 2*Lat; i++) begin
        d3_q[i] <= d3_q[i-1];
      end
      for (int i = 1; i < 3*Lat; i++) begin
        oob_q[i] <= oob_q[i-1];
      end
      out_q <= oob_q[3*Lat-1] ? '0 : m3_r;
    end
  end

  // first multiplier is shared with the build sequencer
  assign m1_v_i = ready ? rv_q : issue;
  assign m1_a   = ready ? fact_rd : acc_q;
  assign m1_b   = ready ? inv1_rd : bld_b;

  mcmp_mulmod u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m1_v_i),
    .a_i     (m1_a),
    .b_i     (m1_b),
    .valid_o (m1_v),
    .res_o   (m1_r)
  );

  mcmp_mulmod u_mul2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m1_v && ready),
    .a_i     (m1_r),
    .b_i     (d2_q[Lat-1]),
    .valid_o (m2_v),
    .res_o   (m2_r)
  );

  mcmp_mulmod u_mul3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m2_v),
    .a_i     (m2_r),
    .b_i     (d3_q[2*Lat-1]),
    .valid_o (m3_v),
    .res_o   (m3_r)
  );

  assign out_valid_o   = out_v_q;
  assign coefficient_o = out_q;

endmodule

// ----- src/mcmp_checker.sv -----
// ----------------------------------------------------------------------------
// mcmp_checker
// port level checks for the multinomial coefficient block
// ----------------------------------------------------------------------------
module mcmp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [mcmp_pkg::FieldW-1:0] total_count_i,
  input logic [mcmp_pkg::FieldW-1:0] first_class_count_i,
  input logic [mcmp_pkg::FieldW-1:0] second_class_count_i,
  input logic [mcmp_pkg::FieldW-1:0] third_class_count_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [mcmp_pkg::CoefW-1:0]  coefficient_o
);
  import mcmp_pkg::*;

  // result is always fully reduced
  a_coef_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (coefficient_o < Prime))
    else $error("coefficient not reduced");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(coefficient_o)))
    else $error("stalled result changed");

  // once tables are ready, input is stalled only behind a waiting result
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !$past(in_stall_o)) |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind multinomial_coefficient_mod_prime mcmp_checker u_mcmp_checker (.*);

// ----- sim/multinomial_coefficient_mod_prime_tb.sv -----
// ----------------------------------------------------------------------------
// multinomial_coefficient_mod_prime_tb
// self-checking bench: directed and random count queries against a local
// factorial / inverse factorial table model, with bursty input and stalls
// ----------------------------------------------------------------------------
module multinomial_coefficient_mod_prime_tb;
  import mcmp_pkg::*;

  localparam int  Depth     = TableDepthDef;
  localparam int  NumRandom = 1750;
  // covers the table build plus stalls and gaps, many times over
  localparam longint CycleLimit = 1000000;
  localparam longint PrimeL = 64'd1000000007;

  typedef struct packed {
    logic [FieldW-1:0] total;
    logic [FieldW-1:0] c1;
    logic [FieldW-1:0] c2;
    logic [FieldW-1:0] c3;
  } query_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [FieldW-1:0] total_count_i = '0;
  logic [FieldW-1:0] first_class_count_i = '0;
  logic [FieldW-1:0] second_class_count_i = '0;
  logic [FieldW-1:0] third_class_count_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CoefW-1:0]  coefficient_o;

  multinomial_coefficient_mod_prime u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .total_count_i, .first_class_count_i,
    .second_class_count_i, .third_class_count_i, .out_valid_o, .out_stall_i, .coefficient_o
  );

  always #1 clk_i = ~clk_i;

  query_t          pending_q[$];
  logic [CoefW-1:0] coef_expected_q[$];
  longint          fact_tab[Depth];
  longint          inv_fact_tab[Depth];
  int              errors = 0;
  int              checked = 0;
  int              zero_seen = 0;
  longint          cycles = 0;
  bit              in_taken = 1'b0;

  function automatic longint mulmod(longint a, longint b);
    return (a * b) % PrimeL;
  endfunction

  function automatic longint powmod(longint base, longint ex);
    longint acc, sq;
    acc = 1;
    sq = base % PrimeL;
    while (ex != 0) begin
      if (ex[0]) acc = mulmod(acc, sq);
      sq = mulmod(sq, sq);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic logic [CoefW-1:0] multinomial_mod(query_t q);
    longint r;
    if (q.total >= Depth || q.c1 >= Depth || q.c2 >= Depth || q.c3 >= Depth) return '0;
    r = mulmod(fact_tab[q.total], inv_fact_tab[q.c1]);
    r = mulmod(r, inv_fact_tab[q.c2]);
    r = mulmod(r, inv_fact_tab[q.c3]);
    return r[CoefW-1:0];
  endfunction

  function automatic query_t mk_query(int n, int a, int b, int c);
    query_t q;
    q.total = FieldW'(n);
    q.c1    = FieldW'(a);
    q.c2    = FieldW'(b);
    q.c3    = FieldW'(c);
    return q;
  endfunction

  function automatic void queue_query(query_t q);
    pending_q.insert(pending_q.size(), q);
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int n, a, b;
    case ($urandom_range(0, 9))
      0: begin // fully random counts, no sum relation
        q = mk_query(int'($urandom()), int'($urandom()), int'($urandom()),
                     int'($urandom()));
      end
      1: begin // small counts
        q = mk_query(int'($urandom_range(0, 15)), int'($urandom_range(0, 15)),
                     int'($urandom_range(0, 15)), int'($urandom_range(0, 15)));
      end
      default: begin // well-formed partition of n
        n = $urandom_range(0, Depth - 1);
        a = $urandom_range(0, n);
        b = $urandom_range(0, n - a);
        q = mk_query(n, a, b, n - a - b);
      end
    endcase
    return q;
  endfunction

  // driver: bursts of random length with random gaps, change on falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        // accepted at the last rising edge: advance or drop valid
        if (pending_q.size() > 0 && burst_left > 0 && gap_left == 0) begin
          burst_left <= burst_left - 1;
          {total_count_i, first_class_count_i, second_class_count_i,
           third_class_count_i} <= pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end else if (pending_q.size() > 0) begin
          in_valid_i <= 1'b1;
          burst_left <= burst_left - 1;
          {total_count_i, first_class_count_i, second_class_count_i,
           third_class_count_i} <= pending_q.pop_front();
        end
      end
    end
  end

  // expectation is formed from the transaction the block takes at the rising edge
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      coef_expected_q.insert(coef_expected_q.size(),
                             multinomial_mod({total_count_i, first_class_count_i,
                                              second_class_count_i, third_class_count_i}));
  end

  // receiver stall pattern: phases of free flow, periodic and random stalls
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= int'((cycles / 500) % 4);
    case (stall_phase)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= (cycles % 5) < 2;
      2: out_stall_i <= $urandom_range(0, 3) == 0;
      default: out_stall_i <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (coef_expected_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual coefficient %0d", $time, coefficient_o);
        errors <= errors + 1;
      end else begin
        if (coefficient_o !== coef_expected_q[0]) begin
          $display("%0t: coefficient mismatch, expected %0d actual %0d",
                   $time, coef_expected_q[0], coefficient_o);
          errors <= errors + 1;
        end
        if (coef_expected_q[0] == 0) zero_seen <= zero_seen + 1;
        void'(coef_expected_q.pop_front());
        checked <= checked + 1;
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, coef_expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    query_t q;
    int k, tail;
    fact_tab[0] = 1;
    for (int i = 1; i < Depth; i++) fact_tab[i] = mulmod(fact_tab[i-1], longint'(i));
    inv_fact_tab[0] = 1;
    for (int i = 1; i < Depth; i++) inv_fact_tab[i] = powmod(fact_tab[i], PrimeL - 2);

    // directed: extremes, trivial and out-of-range-free corners, unbalanced sums
    queue_query(mk_query(0, 0, 0, 0));
    queue_query(mk_query(1, 1, 0, 0));
    queue_query(mk_query(3, 1, 1, 1));
    queue_query(mk_query(4095, 4095, 0, 0));
    queue_query(mk_query(4095, 0, 4095, 0));
    queue_query(mk_query(4095, 0, 0, 4095));
    queue_query(mk_query(4095, 0, 0, 0));
    queue_query(mk_query(4095, 1365, 1365, 1365));
    queue_query(mk_query(4095, 4095, 4095, 4095));
    queue_query(mk_query(0, 4095, 4095, 4095));
    queue_query(mk_query('hAAA, 'h555, 'hAAA, 'h555));
    queue_query(mk_query('h555, 'hAAA, 'h555, 'hAAA));
    queue_query(mk_query(10, 2, 3, 4));   // counts do not sum to n
    queue_query(mk_query(2048, 1024, 1024, 0));
    queue_query(mk_query(4094, 2047, 2047, 0));
    for (k = 0; k < NumRandom; k++) begin
      q = rand_query();
      queue_query(q);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (pending_q.size() > 0 || (in_valid_i === 1'b1)) @(posedge clk_i);
    while (coef_expected_q.size() > 0) @(posedge clk_i);
    tail = 0;
    while (tail < 40) begin
      @(posedge clk_i);
      tail++;
    end

    $display("checked %0d coefficients (%0d zero), directed corners and %0d random queries",
             checked, zero_seen, NumRandom);
    $display("input bursts with gaps and four output stall patterns over %0d cycles", cycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
